@@ sv/emst_pkg.sv @@
// ----------------------------------------------------------------------------
// emst_pkg: shared types and constants of the Euclidean MST length core
// Transfer codes, sequencer states, cell control and default sizes.
// ----------------------------------------------------------------------------
package emst_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF = 20;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned OUT_W          = 40;
  localparam int unsigned MODE_W         = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_ROAD    = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_RELABEL,
    ST_PRIM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

@@ sv/emst_cell.sv @@
// ----------------------------------------------------------------------------
// emst_cell: one ring cell
// Holds one point entry and hands it to the next cell on every shift.
// ----------------------------------------------------------------------------
module emst_cell #(
  parameter int unsigned W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emst_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic [W-1:0]        data_i,
  output logic                valid_o,
  output logic [W-1:0]        data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/emst_sqrt_stage.sv @@
// ----------------------------------------------------------------------------
// emst_sqrt_stage: one base-4 digit of the square root
// Brings down one digit pair and decides one root bit; carries the entry.
// ----------------------------------------------------------------------------
module emst_sqrt_stage #(
  parameter int unsigned P    = 29,
  parameter int unsigned PAIR = 0,
  parameter int unsigned TW   = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [TW-1:0]   tag_i,
  input  logic [2*P-1:0]  rad_i,
  input  logic [P+2:0]    rem_i,
  input  logic [P-1:0]    root_i,
  output logic            valid_o,
  output logic [TW-1:0]   tag_o,
  output logic [2*P-1:0]  rad_o,
  output logic [P+2:0]    rem_o,
  output logic [P-1:0]    root_o
);

  localparam int unsigned RW = P + 3;

  logic          valid_q;
  logic [TW-1:0] tag_q;
  logic [2*P-1:0] rad_q;
  logic [RW-1:0] rem_q;
  logic [P-1:0]  root_q;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;

  assign rem_sh = {rem_i[RW-3:0], rad_i[2*PAIR+1 -: 2]};
  assign trial  = RW'({root_i, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q  <= tag_i;
      rad_q  <= rad_i;
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_i[P-2:0], ge};
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

@@ sv/emst_dist_pipe.sv @@
// ----------------------------------------------------------------------------
// emst_dist_pipe: distance pipeline of the ring
// Absolute differences, squares, sum, then one root digit per stage.
// ----------------------------------------------------------------------------
module emst_dist_pipe #(
  parameter int unsigned C  = 20,
  parameter int unsigned F  = 8,
  parameter int unsigned TW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [TW-1:0]       tag_i,
  input  logic [C-1:0]        x_i,
  input  logic [C-1:0]        y_i,
  input  logic [C-1:0]        cx_i,
  input  logic [C-1:0]        cy_i,
  output logic                valid_o,
  output logic [TW-1:0]       tag_o,
  output logic [C+F:0]        len_o
);

  localparam int unsigned P = C + F + 1;

  logic            a_vld_q, b_vld_q, c_vld_q;
  logic [TW-1:0]   a_tag_q, b_tag_q, c_tag_q;
  logic [C-1:0]    dx_q, dy_q;
  logic [2*C-1:0]  sqx_q, sqy_q;
  logic [2*C:0]    v;
  logic [2*P-1:0]  rad_q;

  logic            s_vld  [P+1];
  logic [TW-1:0]   s_tag  [P+1];
  logic [2*P-1:0]  s_rad  [P+1];
  logic [P+2:0]    s_rem  [P+1];
  logic [P-1:0]    s_root [P+1];

  assign v = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_tag_q <= tag_i;
      dx_q    <= (x_i > cx_i) ? (x_i - cx_i) : (cx_i - x_i);
      dy_q    <= (y_i > cy_i) ? (y_i - cy_i) : (cy_i - y_i);
      b_tag_q <= a_tag_q;
      sqx_q   <= dx_q * dx_q;
      sqy_q   <= dy_q * dy_q;
      c_tag_q <= b_tag_q;
      rad_q   <= {{(2*P-2*C-1){1'b0}}, v} << (2*F);
    end
  end

  assign s_vld[0]  = c_vld_q;
  assign s_tag[0]  = c_tag_q;
  assign s_rad[0]  = rad_q;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;

  for (genvar k = 0; k < P; k++) begin : g_root
    emst_sqrt_stage #(
      .P    (P),
      .PAIR (P - 1 - k),
      .TW   (TW)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (s_vld[k]),
      .tag_i   (s_tag[k]),
      .rad_i   (s_rad[k]),
      .rem_i   (s_rem[k]),
      .root_i  (s_root[k]),
      .valid_o (s_vld[k+1]),
      .tag_o   (s_tag[k+1]),
      .rad_o   (s_rad[k+1]),
      .rem_o   (s_rem[k+1]),
      .root_o  (s_root[k+1])
    );
  end

  assign valid_o = s_vld[P];
  assign tag_o   = s_tag[P];
  assign len_o   = s_root[P];

endmodule

@@ sv/euclidean_mst_length_core.sv @@
// ----------------------------------------------------------------------------
// euclidean_mst_length_core: Euclidean minimum spanning tree length
// Ring of point cells with a distance pipeline; Prim's method over the ring.
// ----------------------------------------------------------------------------
// Points sit in a ring of MAX_POINTS cells closed through a distance pipeline
// of COORD_BITS+FRAC_BITS+4 stages; R = MAX_POINTS+COORD_BITS+FRAC_BITS+4 is
// one full turn of the ring. A point load enters the first cell. A road runs
// a find turn, reading the component labels of its ends, then a relabel turn.
// A compute transfer runs tree turns over the ring, each adding one tree
// point, until a turn finds none; it then hands over the result once the
// output is free. With fewer than two points it goes straight to the result
// hand-over. After a compute the point set is empty again.
module euclidean_mst_length_core #(
  parameter int unsigned MAX_POINTS = emst_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = emst_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = emst_pkg::FRAC_BITS_DEF,
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1),
  localparam int unsigned TDI = ((2 * COORD_BITS + 2 * CW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // x_coord, y_coord, end_a, end_b, zero pad
  input  logic [TDI-1:0]               s_axis_tdata_i,
  // mode
  input  logic [emst_pkg::MODE_W-1:0]  s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // total_length
  output logic [emst_pkg::OUT_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned IW     = $clog2(MAX_POINTS);
  localparam int unsigned LW     = C + FRAC_BITS + 1;
  localparam int unsigned TW     = 1 + 2 * IW + 2 * C + LW;
  localparam int unsigned RING   = MAX_POINTS + LW + 3;
  localparam int unsigned KW     = $clog2(RING);
  localparam int unsigned O_IDX  = 1;
  localparam int unsigned O_LBL  = 1 + IW;
  localparam int unsigned O_X    = 1 + 2 * IW;
  localparam int unsigned O_Y    = O_X + C;
  localparam int unsigned O_BEST = O_Y + C;
  localparam int unsigned OW     = emst_pkg::OUT_W;

  emst_pkg::state_e state_q, state_d;
  emst_pkg::mode_e  mode;
  emst_pkg::cell_ctrl_t ctrl;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [KW-1:0] cyc_q, cyc_d;
  logic [IW-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [IW-1:0] la_q, la_d, lb_q, lb_d;
  logic [IW-1:0] cur_idx_q, cur_idx_d, cur_lbl_q, cur_lbl_d;
  logic [C-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic          cand_f_q, cand_f_d;
  logic [LW-1:0] cand_best_q, cand_best_d;
  logic [IW-1:0] cand_idx_q, cand_idx_d, cand_lbl_q, cand_lbl_d;
  logic [C-1:0]  cand_x_q, cand_x_d, cand_y_q, cand_y_d;
  logic [OW-1:0] sum_q, sum_d;
  logic [OW:0]   sum_ext;
  logic          m_valid_q, m_valid_d;
  logic [OW-1:0] m_data_q, m_data_d;

  logic [C-1:0]  x_in, y_in;
  logic [CW-1:0] a_in, b_in;
  logic          ends_ok, run, load, pass_end;

  logic          cv [MAX_POINTS];
  logic [TW-1:0] cd [MAX_POINTS];
  logic          p_valid;
  logic [TW-1:0] p_tag;
  logic [LW-1:0] p_len;
  logic [TW-1:0] head_tag, load_tag;
  logic          in_valid;
  logic [TW-1:0] in_tag;
  logic [LW-1:0] w, nb;

  assign x_in = s_axis_tdata_i[C-1:0];
  assign y_in = s_axis_tdata_i[2*C-1:C];
  assign a_in = s_axis_tdata_i[2*C+CW-1:2*C];
  assign b_in = s_axis_tdata_i[2*C+2*CW-1:2*C+CW];
  assign mode = emst_pkg::mode_e'(s_axis_tuser_i);

  assign ends_ok = (a_in != '0) && (a_in <= cnt_q) && (b_in != '0) && (b_in <= cnt_q);
  assign run = (state_q == emst_pkg::ST_FIND) || (state_q == emst_pkg::ST_RELABEL) ||
               (state_q == emst_pkg::ST_PRIM);
  assign pass_end = (cyc_q == KW'(RING - 1));

  assign load_tag = {{LW{1'b1}}, y_in, x_in, cnt_q[IW-1:0], cnt_q[IW-1:0], 1'b0};
  assign in_valid = load ? 1'b1 : p_valid;
  assign in_tag   = load ? load_tag : head_tag;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    if (k == 0) begin : g_first
      emst_cell #(.W(TW)) u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl),
        .valid_i (in_valid), .data_i (in_tag),
        .valid_o (cv[k]), .data_o (cd[k])
      );
    end else begin : g_rest
      emst_cell #(.W(TW)) u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl),
        .valid_i (cv[k-1]), .data_i (cd[k-1]),
        .valid_o (cv[k]), .data_o (cd[k])
      );
    end
  end

  emst_dist_pipe #(
    .C  (C),
    .F  (FRAC_BITS),
    .TW (TW)
  ) u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (run),
    .valid_i (cv[MAX_POINTS-1]),
    .tag_i   (cd[MAX_POINTS-1]),
    .x_i     (cd[MAX_POINTS-1][O_X +: C]),
    .y_i     (cd[MAX_POINTS-1][O_Y +: C]),
    .cx_i    (cur_x_q),
    .cy_i    (cur_y_q),
    .valid_o (p_valid),
    .tag_o   (p_tag),
    .len_o   (p_len)
  );

  // same component costs nothing
  assign w  = (p_tag[O_LBL +: IW] == cur_lbl_q) ? '0 : p_len;
  assign nb = (w < p_tag[O_BEST +: LW]) ? w : p_tag[O_BEST +: LW];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cyc_d       = cyc_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    la_d        = la_q;
    lb_d        = lb_q;
    cur_idx_d   = cur_idx_q;
    cur_lbl_d   = cur_lbl_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    cand_f_d    = cand_f_q;
    cand_best_d = cand_best_q;
    cand_idx_d  = cand_idx_q;
    cand_lbl_d  = cand_lbl_q;
    cand_x_d    = cand_x_q;
    cand_y_d    = cand_y_q;
    sum_d       = sum_q;
    sum_ext     = '0;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;
    head_tag    = p_tag;
    load        = 1'b0;
    ctrl.shift  = run;
    ctrl.clear  = 1'b0;
    s_axis_tready_o = (state_q == emst_pkg::ST_IDLE);

    case (state_q)
      emst_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          case (mode)
            emst_pkg::MODE_LOAD: begin
              if (cnt_q < CW'(MAX_POINTS)) begin
                load       = 1'b1;
                ctrl.shift = 1'b1;
                cnt_d      = cnt_q + 1'b1;
                if (cnt_q == '0) begin
                  cur_x_d   = x_in;
                  cur_y_d   = y_in;
                  cur_lbl_d = '0;
                end
              end
            end
            emst_pkg::MODE_ROAD: begin
              if (ends_ok) begin
                ra_d    = IW'(a_in - 1'b1);
                rb_d    = IW'(b_in - 1'b1);
                cyc_d   = '0;
                state_d = emst_pkg::ST_FIND;
              end
            end
            emst_pkg::MODE_COMPUTE: begin
              sum_d     = '0;
              cand_f_d  = 1'b0;
              cur_idx_d = '0;
              cyc_d     = '0;
              state_d   = (cnt_q < CW'(2)) ? emst_pkg::ST_EMIT : emst_pkg::ST_PRIM;
            end
            default: ;
          endcase
        end
      end
      emst_pkg::ST_FIND: begin
        if (p_valid) begin
          if (p_tag[O_IDX +: IW] == ra_q) la_d = p_tag[O_LBL +: IW];
          if (p_tag[O_IDX +: IW] == rb_q) lb_d = p_tag[O_LBL +: IW];
        end
        cyc_d = pass_end ? '0 : cyc_q + 1'b1;
        if (pass_end) state_d = emst_pkg::ST_RELABEL;
      end
      emst_pkg::ST_RELABEL: begin
        if (p_valid && (p_tag[O_LBL +: IW] == la_q)) begin
          head_tag[O_LBL +: IW] = lb_q;
          if (p_tag[O_IDX +: IW] == '0) cur_lbl_d = lb_q;
        end
        cyc_d = pass_end ? '0 : cyc_q + 1'b1;
        if (pass_end) state_d = emst_pkg::ST_IDLE;
      end
      emst_pkg::ST_PRIM: begin
        if (p_valid && !p_tag[0]) begin
          if (p_tag[O_IDX +: IW] == cur_idx_q) begin
            head_tag[0] = 1'b1;
          end else begin
            head_tag[O_BEST +: LW] = nb;
            if (!cand_f_q || (nb < cand_best_q)) begin
              cand_f_d    = 1'b1;
              cand_best_d = nb;
              cand_idx_d  = p_tag[O_IDX +: IW];
              cand_lbl_d  = p_tag[O_LBL +: IW];
              cand_x_d    = p_tag[O_X +: C];
              cand_y_d    = p_tag[O_Y +: C];
            end
          end
        end
        cyc_d = pass_end ? '0 : cyc_q + 1'b1;
        if (pass_end) begin
          if (cand_f_d) begin
            cur_idx_d = cand_idx_d;
            cur_lbl_d = cand_lbl_d;
            cur_x_d   = cand_x_d;
            cur_y_d   = cand_y_d;
            sum_ext   = {1'b0, sum_q} + (OW + 1)'(cand_best_d);
            sum_d     = sum_ext[OW] ? {OW{1'b1}} : sum_ext[OW-1:0];
            cand_f_d  = 1'b0;
          end else begin
            state_d = emst_pkg::ST_EMIT;
          end
        end
      end
      emst_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          m_data_d   = sum_q;
          ctrl.clear = 1'b1;
          cnt_d      = '0;
          state_d    = emst_pkg::ST_IDLE;
        end
      end
      default: state_d = emst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= emst_pkg::ST_IDLE;
      cnt_q     <= '0;
      cyc_q     <= '0;
      cand_f_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cyc_q     <= cyc_d;
      cand_f_q  <= cand_f_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q        <= ra_d;
    rb_q        <= rb_d;
    la_q        <= la_d;
    lb_q        <= lb_d;
    cur_idx_q   <= cur_idx_d;
    cur_lbl_q   <= cur_lbl_d;
    cur_x_q     <= cur_x_d;
    cur_y_q     <= cur_y_d;
    cand_best_q <= cand_best_d;
    cand_idx_q  <= cand_idx_d;
    cand_lbl_q  <= cand_lbl_d;
    cand_x_q    <= cand_x_d;
    cand_y_q    <= cand_y_d;
    sum_q       <= sum_d;
    m_data_q    <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("point count above capacity");

  a_prim_pts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == emst_pkg::ST_PRIM) |-> (cnt_q >= CW'(2)))
    else $error("tree pass with fewer than two points");

  a_cyc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cyc_q <= KW'(RING - 1))
    else $error("ring turn counter out of range");

  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == emst_pkg::ST_EMIT && state_d == emst_pkg::ST_IDLE)
      |=> (cnt_q == '0 && m_valid_q))
    else $error("result transfer did not empty the point set");

endmodule

@@ test/tb_euclidean_mst_length_core.sv @@
// ----------------------------------------------------------------------------
// tb_euclidean_mst_length_core: self-checking bench for the EMST length core
// Streams point, road and compute transfers into the core. Each expected
// total comes from a Prim model with union-find grouping of roads, and the
// bench compares it with what the core hands out. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_euclidean_mst_length_core;

  localparam int unsigned NPTS   = emst_pkg::MAX_POINTS_DEF;
  localparam int unsigned CBITS  = emst_pkg::COORD_BITS_DEF;
  localparam int unsigned FBITS  = emst_pkg::FRAC_BITS_DEF;
  localparam int unsigned CW     = $clog2(NPTS + 1);
  localparam int unsigned TDI    = ((2 * CBITS + 2 * CW + 7) / 8) * 8;
  localparam logic [emst_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
  localparam longint unsigned LEN_MAX = (64'd1 << emst_pkg::OUT_W) - 1;
  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;
  localparam int unsigned RING = NPTS + CBITS + FBITS + 4;

  typedef struct {
    logic [emst_pkg::MODE_W-1:0] mode;
    logic [CBITS-1:0]  x;
    logic [CBITS-1:0]  y;
    logic [CW-1:0]     end_a;
    logic [CW-1:0]     end_b;
  } emst_item_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_valid;
  logic               s_ready;
  logic [TDI-1:0]     s_data;
  logic [emst_pkg::MODE_W-1:0] s_user;
  logic               m_valid;
  logic               m_ready;
  logic [emst_pkg::OUT_W-1:0]  m_data;

  euclidean_mst_length_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // ---------------- point-set model ----------------
  logic [CBITS-1:0]  pt_x [NPTS];
  logic [CBITS-1:0]  pt_y [NPTS];
  int unsigned       grp_up [NPTS];
  int unsigned       pt_count;

  emst_item_t        pending_items[$];
  longint unsigned   expected_totals[$];
  int unsigned       mismatches;
  int unsigned       totals_seen;
  int unsigned       items_sent;
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                recv_hold;
  bit                hold_go;
  emst_item_t        cur_item;
  bit                s_fire;
  longint unsigned   cycle_cnt;

  function automatic void clear_set();
    for (int i = 0; i < NPTS; i++) grp_up[i] = i;
    pt_count = 0;
  endfunction

  function automatic int unsigned group_of(int unsigned k);
    int unsigned up;
    for (int s = 0; s < NPTS; s++) begin
      up = grp_up[k];
      if (up == k) break;
      k = up;
    end
    return k;
  endfunction

  // floor(sqrt(v)) bit by bit
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned link_length(int unsigned i, int unsigned j);
    longint unsigned dx, dy;
    dx = (pt_x[i] > pt_x[j]) ? pt_x[i] - pt_x[j] : pt_x[j] - pt_x[i];
    dy = (pt_y[i] > pt_y[j]) ? pt_y[i] - pt_y[j] : pt_y[j] - pt_y[i];
    return isqrt((dx * dx + dy * dy) << (2 * FBITS));
  endfunction

  function automatic longint unsigned tree_length();
    int unsigned     grp [NPTS];
    longint unsigned best [NPTS];
    bit              taken [NPTS];
    longint unsigned sum, w;
    int unsigned     pick;
    if (pt_count < 2) return 0;
    for (int i = 0; i < pt_count; i++) begin
      grp[i] = group_of(i);
      taken[i] = 1'b0;
      best[i] = '1;
    end
    best[0] = 0;
    sum = 0;
    for (int s = 0; s < pt_count; s++) begin
      pick = pt_count;
      for (int i = 0; i < pt_count; i++)
        if (!taken[i] && (pick == pt_count || best[i] < best[pick])) pick = i;
      taken[pick] = 1'b1;
      sum += best[pick];
      for (int i = 0; i < pt_count; i++)
        if (!taken[i]) begin
          w = (grp[i] == grp[pick]) ? 0 : link_length(pick, i);
          if (w < best[i]) best[i] = w;
        end
    end
    return (sum > LEN_MAX) ? LEN_MAX : sum;
  endfunction

  task automatic apply_item(input emst_item_t it);
    int unsigned ra, rb;
    case (it.mode)
      emst_pkg::MODE_LOAD: begin
        if (pt_count < NPTS) begin
          pt_x[pt_count] = it.x;
          pt_y[pt_count] = it.y;
          pt_count++;
        end
      end
      emst_pkg::MODE_ROAD: begin
        if (it.end_a >= 1 && it.end_a <= pt_count && it.end_b >= 1 && it.end_b <= pt_count) begin
          ra = group_of(it.end_a - 1);
          rb = group_of(it.end_b - 1);
          if (ra != rb) grp_up[ra] = rb;
        end
      end
      emst_pkg::MODE_COMPUTE: begin
        expected_totals.insert(expected_totals.size(), tree_length());
        clear_set();
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input longint unsigned got, input longint unsigned want,
                                 input bit orphan);
    mismatches++;
    if (orphan) $display("ERROR: unexpected total_length %0d", got);
    else $display("ERROR: total_length got %0d want %0d (result %0d)", got, want, totals_seen);
  endtask

  // ---------------- stimulus helpers ----------------
  task automatic push(input logic [emst_pkg::MODE_W-1:0] mode, input int unsigned x,
                      input int unsigned y, input int unsigned ea, input int unsigned eb);
    emst_item_t it;
    it.mode = mode;
    it.x = CBITS'(x);
    it.y = CBITS'(y);
    it.end_a = CW'(ea);
    it.end_b = CW'(eb);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic int unsigned rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return (1 << CBITS) - 1 - $urandom_range(0, 15);
      2: return $urandom_range(0, 4095);
      default: return $urandom_range(0, (1 << CBITS) - 1);
    endcase
  endfunction

  function automatic int unsigned rand_end(int unsigned n);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return n + 1;
      2: return $urandom_range(0, (1 << CW) - 1);
      default: return $urandom_range(1, (n == 0) ? 1 : n);
    endcase
  endfunction

  // one set: loads, up to two roads with possibly bad ends, sometimes mode-3 noise, compute
  task automatic add_set();
    int unsigned n, roads;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
    roads = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    for (int i = 0; i < n; i++) push(emst_pkg::MODE_LOAD, rand_coord(), rand_coord(), 0, 0);
    for (int i = 0; i < roads; i++) push(emst_pkg::MODE_ROAD, 0, 0, rand_end(n), rand_end(n));
    if ($urandom_range(0, 9) == 0)
      push(MODE_NOP, rand_coord(), rand_coord(), rand_end(n), rand_end(n));
    push(emst_pkg::MODE_COMPUTE, rand_coord(), rand_coord(), 0, 0);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || s_valid || expected_totals.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------- driver / monitor ----------------
  always @(posedge clk_i) begin
    s_fire = s_valid && s_ready;
    if (s_fire) begin
      apply_item(cur_item);
      items_sent++;
    end
    if (m_valid && m_ready) begin
      totals_seen++;
      if (expected_totals.size() == 0) report_mismatch(m_data, 0, 1'b1);
      else if (m_data !== expected_totals[0][emst_pkg::OUT_W-1:0])
        report_mismatch(m_data, expected_totals.pop_front(), 1'b0);
      else void'(expected_totals.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_valid || s_fire) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          s_valid <= 1'b1;
          s_user  <= cur_item.mode;
          s_data  <= {{(TDI - 2 * CBITS - 2 * CW){1'b0}}, cur_item.end_b, cur_item.end_a,
                      cur_item.y, cur_item.x};
        end else begin
          s_valid <= 1'b0;
        end
      end
      m_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off while inputs keep coming
  initial begin
    recv_hold = 1'b0;
    wait (hold_go);
    recv_hold = 1'b1;
    repeat (4 * RING) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    s_valid = 1'b0;
    s_data = '0;
    s_user = emst_pkg::MODE_LOAD;
    m_ready = 1'b0;
    s_fire = 1'b0;
    hold_go = 1'b0;
    mismatches = 0;
    totals_seen = 0;
    items_sent = 0;
    cycle_cnt = 0;
    send_idle_pct = 33;
    recv_idle_pct = 55;
    clear_set();
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty set, single point, coordinate extremes
    push(emst_pkg::MODE_COMPUTE, 0, 0, 0, 0);
    push(emst_pkg::MODE_LOAD, 7, 9, 0, 0);
    push(emst_pkg::MODE_COMPUTE, 0, 0, 0, 0);
    push(emst_pkg::MODE_LOAD, 0, 0, 0, 0);
    push(emst_pkg::MODE_LOAD, (1 << CBITS) - 1, (1 << CBITS) - 1, 0, 0);
    push(emst_pkg::MODE_LOAD, (1 << CBITS) - 1, 0, 0, 0);
    push(emst_pkg::MODE_LOAD, 3, 4, 0, 0);
    // roads: to itself, bad ends, valid, within one group, mode 3 noise
    push(emst_pkg::MODE_ROAD, 0, 0, 2, 2);
    push(emst_pkg::MODE_ROAD, 0, 0, 0, 1);
    push(emst_pkg::MODE_ROAD, 0, 0, 1, 5);
    push(emst_pkg::MODE_ROAD, 0, 0, (1 << CW) - 1, 2);
    push(emst_pkg::MODE_ROAD, 0, 0, 1, 2);
    push(emst_pkg::MODE_ROAD, 0, 0, 2, 1);
    push(MODE_NOP, (1 << CBITS) - 1, (1 << CBITS) - 1, (1 << CW) - 1, (1 << CW) - 1);
    push(emst_pkg::MODE_COMPUTE, 0, 0, 0, 0);
    // full store: one point past the limit is dropped
    for (int i = 0; i <= NPTS; i++)
      push(emst_pkg::MODE_LOAD, rand_coord(), rand_coord(), 0, 0);
    push(emst_pkg::MODE_ROAD, 0, 0, NPTS, 1);
    push(emst_pkg::MODE_COMPUTE, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 55 : 0;
      recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 33 : 0;
      while (pending_items.size() < 290) add_set();
      if (ph == 0) begin
        @(posedge clk_i);
        hold_go = 1'b1;
      end
      drain();
    end

    repeat (RING + 50) @(posedge clk_i);
    $display("sent %0d transfers, checked %0d totals incl. empty, single, road and full sets",
             items_sent, totals_seen);
    if (mismatches == 0 && expected_totals.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d totals outstanding", mismatches, expected_totals.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
